### hdl/mmasr_pkg.sv
package mmasr_pkg;

    // Fixed widths of the sample and statistic words, the settings and the register bus.
    localparam int DATA_W     = 64;
    localparam int STEP_W     = $clog2(DATA_W);
    localparam int KIND_W     = 2;
    localparam int MODE_W     = 2;
    localparam int INTERVAL_W = 32;
    localparam int ADDR_W     = 4;
    localparam int PDATA_W    = 32;

    // Aggregate modes.
    localparam logic [MODE_W-1:0] MODE_ALL      = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MIN_ONLY = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MAX_ONLY = 2'd2;
    localparam logic [MODE_W-1:0] MODE_AVG_ONLY = 2'd3;

    // Statistic kinds carried with each result word.
    localparam logic [KIND_W-1:0] KIND_MIN = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MAX = 2'd1;
    localparam logic [KIND_W-1:0] KIND_AVG = 2'd2;

    // Register indexes (word address bits of paddr).
    localparam logic [1:0] REG_MODE     = 2'd0;
    localparam logic [1:0] REG_INTERVAL = 2'd1;
    localparam logic [1:0] REG_FORCE    = 2'd2;
    localparam logic [1:0] REG_ENABLED  = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0]     mode;
        logic [INTERVAL_W-1:0] interval;
        logic                  force_rpt;
        logic                  enabled;
    } t_cfg;

    typedef struct packed {
        logic              fold;
        logic              decide;
        logic              div_start;
        logic              load_out;
        logic [KIND_W-1:0] out_kind;
        logic              out_last;
        logic              clear;
    } t_dp_cmd;

    typedef struct packed {
        logic report_due;
        logic div_done;
        logic out_free;
    } t_dp_status;

endpackage

### hdl/mmasr_ifs.sv
interface mmasr_in_if #(
    parameter int TIME_WIDTH = 48
);
    logic                  valid;
    logic                  ready;
    logic signed [63:0]    sample_value;
    logic [TIME_WIDTH-1:0] sample_time;

    modport source (output valid, output sample_value, output sample_time, input ready);
    modport sink   (input valid, input sample_value, input sample_time, output ready);
endinterface

interface mmasr_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         stat_kind;
    logic signed [63:0] stat_value;
    logic               last;

    modport source (output valid, output stat_kind, output stat_value, output last, input ready);
    modport sink   (input valid, input stat_kind, input stat_value, input last, output ready);
endinterface

### hdl/min_max_avg_stats_reporter.sv
// Rate-limited min/max/average reporter. Each input word is one signed 64-bit
// sample with a tick timestamp; the block folds it into a saturating sample
// count and, as the aggregate mode asks, a running minimum, maximum and
// wrapping sum. When reporting is enabled and the sample time has reached the
// stored deadline (or force_report is set), the deadline moves to sample time
// plus report_interval and the block emits min, max and average in that order
// (mode all) or the single selected statistic, with last set on the final
// word, then clears the aggregates. The average is the sum divided by the
// count, truncated toward zero. Steps: a sample that triggers no report
// passes through accept, then deadline check; a min-only or max-only report
// adds the emission of its result word; a report that includes the average
// adds the bit-serial divider (64 quotient bits, then a check of its done
// flag) before the result words. The divider produces one quotient bit per
// cycle. A sink that holds off while a result word waits delays the report
// further. A new sample is taken as soon as the last result word of a
// report sits in the output register, even if the sink has not taken it yet.
// Registers (APB, byte addresses): 0x0 aggregate_mode, 0x4 report_interval,
// 0x8 force_report, 0xC enabled. Reset leaves enabled at 1 and all else at 0.
module min_max_avg_stats_reporter #(
    parameter int TIME_WIDTH  = 48,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    mmasr_in_if.sink                         i_sample,
    mmasr_out_if.source                      o_stat,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [mmasr_pkg::ADDR_W-1:0]     paddr,
    input  logic [mmasr_pkg::PDATA_W-1:0]    pwdata,
    output logic [mmasr_pkg::PDATA_W-1:0]    prdata,
    output logic                             pready
);

    localparam int PW = mmasr_pkg::PDATA_W;

    logic [mmasr_pkg::MODE_W-1:0]     r_mode;
    logic [mmasr_pkg::INTERVAL_W-1:0] r_interval;
    logic                             r_force;
    logic                             r_enabled;

    mmasr_pkg::t_cfg       w_cfg;
    mmasr_pkg::t_dp_cmd    w_cmd;
    mmasr_pkg::t_dp_status w_status;
    logic                  w_wr;
    logic [1:0]            w_reg;

    // The bus never stalls, so a write lands on its access cycle.
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_reg  = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= mmasr_pkg::MODE_ALL;
            r_interval <= '0;
            r_force    <= 1'b0;
            r_enabled  <= 1'b1;
        end else if (w_wr) begin
            case (w_reg)
                mmasr_pkg::REG_MODE:     r_mode     <= pwdata[mmasr_pkg::MODE_W-1:0];
                mmasr_pkg::REG_INTERVAL: r_interval <= pwdata[mmasr_pkg::INTERVAL_W-1:0];
                mmasr_pkg::REG_FORCE:    r_force    <= pwdata[0];
                mmasr_pkg::REG_ENABLED:  r_enabled  <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_reg)
            mmasr_pkg::REG_MODE:     prdata = PW'(r_mode);
            mmasr_pkg::REG_INTERVAL: prdata = PW'(r_interval);
            mmasr_pkg::REG_FORCE:    prdata = PW'(r_force);
            mmasr_pkg::REG_ENABLED:  prdata = PW'(r_enabled);
            default:                 prdata = '0;
        endcase
    end

    assign w_cfg.mode      = r_mode;
    assign w_cfg.interval  = r_interval;
    assign w_cfg.force_rpt = r_force;
    assign w_cfg.enabled   = r_enabled;

    // The controller sequences accept, deadline check, division and the
    // result words; the datapath holds the aggregates and the output register.
    mmasr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_mode     (r_mode),
        .i_in_valid (i_sample.valid),
        .o_in_ready (i_sample.ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    mmasr_dp #(
        .TIME_WIDTH  (TIME_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (w_cfg),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_sample_value (i_sample.sample_value),
        .i_sample_time  (i_sample.sample_time),
        .i_out_ready    (o_stat.ready),
        .o_out_valid    (o_stat.valid),
        .o_stat_kind    (o_stat.stat_kind),
        .o_stat_value   (o_stat.stat_value),
        .o_last         (o_stat.last)
    );

endmodule

### hdl/mmasr_div.sv
module mmasr_div #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [mmasr_pkg::DATA_W-1:0] i_dividend,
    input  logic [COUNT_WIDTH-1:0]       i_divisor,
    output logic [mmasr_pkg::DATA_W-1:0] o_quotient,
    output logic                         o_done
);

    localparam int DW = mmasr_pkg::DATA_W;
    localparam int SW = mmasr_pkg::STEP_W;

    logic [COUNT_WIDTH-1:0] r_rem;
    logic [COUNT_WIDTH-1:0] r_divisor;
    logic [DW-1:0]          r_quo;
    logic [SW-1:0]          r_step;
    logic                   r_busy;
    logic                   r_done;

    logic [COUNT_WIDTH:0]   w_shifted;
    logic [COUNT_WIDTH:0]   w_diff;
    logic                   w_ge;

    // Restoring division, one quotient bit per cycle. The dividend bits shift
    // out of the top of r_quo while quotient bits shift in at the bottom.
    assign w_shifted = {r_rem, r_quo[DW-1]};
    assign w_diff    = w_shifted - {1'b0, r_divisor};
    assign w_ge      = ~w_diff[COUNT_WIDTH];

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem     <= '0;
            r_divisor <= i_divisor;
            r_quo     <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[COUNT_WIDTH-1:0] : w_shifted[COUNT_WIDTH-1:0];
            r_quo <= {r_quo[DW-2:0], w_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (r_busy) begin
            r_step <= r_step + 1'b1;
            if (r_step == SW'(DW - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

endmodule

### hdl/mmasr_dp.sv
module mmasr_dp #(
    parameter int TIME_WIDTH  = 48,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mmasr_pkg::t_cfg                     i_cfg,
    input  mmasr_pkg::t_dp_cmd                  i_cmd,
    output mmasr_pkg::t_dp_status               o_status,
    input  logic signed [mmasr_pkg::DATA_W-1:0] i_sample_value,
    input  logic [TIME_WIDTH-1:0]               i_sample_time,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [mmasr_pkg::KIND_W-1:0]        o_stat_kind,
    output logic signed [mmasr_pkg::DATA_W-1:0] o_stat_value,
    output logic                                o_last
);

    localparam int DW    = mmasr_pkg::DATA_W;
    localparam int IW    = mmasr_pkg::INTERVAL_W;
    localparam int DL_W  = TIME_WIDTH + 1;
    localparam int SUM_W = ((TIME_WIDTH > IW) ? TIME_WIDTH : IW) + 1;
    localparam logic signed [DW-1:0] S_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] S_MIN = {1'b1, {(DW-1){1'b0}}};

    logic signed [DW-1:0]    r_min;
    logic signed [DW-1:0]    r_max;
    logic [DW-1:0]           r_sum;
    logic [COUNT_WIDTH-1:0]  r_count;
    logic [DL_W-1:0]         r_deadline;
    logic [TIME_WIDTH-1:0]   r_time;
    logic                    r_avg_neg;

    logic                    r_out_valid;
    logic [mmasr_pkg::KIND_W-1:0] r_out_kind;
    logic [DW-1:0]           r_out_value;
    logic                    r_out_last;

    logic                    w_want_min;
    logic                    w_want_max;
    logic                    w_want_avg;
    logic [SUM_W-1:0]        w_next_deadline;
    logic [DW-1:0]           w_sum_mag;
    logic [DW-1:0]           w_quotient;
    logic [DW-1:0]           w_average;
    logic [DW-1:0]           w_out_value;
    logic                    w_div_done;

    assign w_want_min = i_cfg.mode inside {mmasr_pkg::MODE_ALL, mmasr_pkg::MODE_MIN_ONLY};
    assign w_want_max = i_cfg.mode inside {mmasr_pkg::MODE_ALL, mmasr_pkg::MODE_MAX_ONLY};
    assign w_want_avg = i_cfg.mode inside {mmasr_pkg::MODE_ALL, mmasr_pkg::MODE_AVG_ONLY};

    assign w_next_deadline = SUM_W'(r_time) + SUM_W'(i_cfg.interval);

    // Sum magnitude for the unsigned divider; sign is restored afterwards.
    assign w_sum_mag = r_sum[DW-1] ? (DW'(0) - r_sum) : r_sum;
    assign w_average = r_avg_neg ? (DW'(0) - w_quotient) : w_quotient;

    mmasr_div #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_sum_mag),
        .i_divisor  (r_count),
        .o_quotient (w_quotient),
        .o_done     (w_div_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_min   <= S_MAX;
            r_max   <= S_MIN;
            r_sum   <= '0;
            r_count <= '0;
        end else if (i_cmd.fold) begin
            if (r_count != '1) begin
                r_count <= r_count + 1'b1;
            end
            if (w_want_avg) begin
                r_sum <= r_sum + i_sample_value;
            end
            if (w_want_min && (i_sample_value < r_min)) begin
                r_min <= i_sample_value;
            end
            if (w_want_max && (i_sample_value > r_max)) begin
                r_max <= i_sample_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadline <= '0;
        end else if (i_cmd.decide && o_status.report_due) begin
            r_deadline <= w_next_deadline[DL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fold) begin
            r_time <= i_sample_time;
        end
        if (i_cmd.div_start) begin
            r_avg_neg <= r_sum[DW-1];
        end
    end

    always_comb begin
        case (i_cmd.out_kind)
            mmasr_pkg::KIND_MIN: w_out_value = r_min;
            mmasr_pkg::KIND_MAX: w_out_value = r_max;
            default:             w_out_value = w_average;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_kind  <= i_cmd.out_kind;
            r_out_value <= w_out_value;
            r_out_last  <= i_cmd.out_last;
        end
    end

    assign o_status.report_due = i_cfg.enabled
                               && (i_cfg.force_rpt || ({1'b0, r_time} >= r_deadline));
    assign o_status.div_done   = w_div_done;
    assign o_status.out_free   = ~r_out_valid | i_out_ready;

    assign o_out_valid  = r_out_valid;
    assign o_stat_kind  = r_out_kind;
    assign o_stat_value = r_out_value;
    assign o_last       = r_out_last;

endmodule

### hdl/mmasr_ctrl.sv
module mmasr_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [mmasr_pkg::MODE_W-1:0] i_mode,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  mmasr_pkg::t_dp_status      i_status,
    output mmasr_pkg::t_dp_cmd         o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_DECIDE = 4'b0010,
        S_DIV    = 4'b0100,
        S_EMIT   = 4'b1000
    } t_state;

    t_state                       r_state;
    t_state                       n_state;
    logic [mmasr_pkg::KIND_W-1:0] r_kind;
    logic [mmasr_pkg::KIND_W-1:0] n_kind;
    logic                         w_last;

    assign w_last = (i_mode != mmasr_pkg::MODE_ALL) || (r_kind == mmasr_pkg::KIND_AVG);

    always_comb begin
        n_state    = r_state;
        n_kind     = r_kind;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.fold = 1'b1;
                    n_state    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                if (i_status.report_due) begin
                    case (i_mode)
                        mmasr_pkg::MODE_MAX_ONLY: n_kind = mmasr_pkg::KIND_MAX;
                        mmasr_pkg::MODE_AVG_ONLY: n_kind = mmasr_pkg::KIND_AVG;
                        default:                  n_kind = mmasr_pkg::KIND_MIN;
                    endcase
                    if (i_mode inside {mmasr_pkg::MODE_ALL, mmasr_pkg::MODE_AVG_ONLY}) begin
                        o_cmd.div_start = 1'b1;
                        n_state         = S_DIV;
                    end else begin
                        n_state = S_EMIT;
                    end
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.out_kind = r_kind;
                    o_cmd.out_last = w_last;
                    if (w_last) begin
                        o_cmd.clear = 1'b1;
                        n_state     = S_IDLE;
                    end else if (r_kind == mmasr_pkg::KIND_MIN) begin
                        n_kind = mmasr_pkg::KIND_MAX;
                    end else begin
                        n_kind = mmasr_pkg::KIND_AVG;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kind  <= mmasr_pkg::KIND_MIN;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
        end
    end

endmodule

### verif/stats_monitor.sv
// Watches the sample, stat and register ports, predicts the stat words that
// each accepted sample must produce, and compares them in order.
module stats_monitor import mmasr_pkg::*; #(
    parameter int TIME_WIDTH  = 48,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_sample_valid,
    input  logic                  i_sample_ready,
    input  logic [DATA_W-1:0]     i_sample_value,
    input  logic [TIME_WIDTH-1:0] i_sample_time,
    input  logic                  i_stat_valid,
    input  logic                  i_stat_ready,
    input  logic [KIND_W-1:0]     i_stat_kind,
    input  logic [DATA_W-1:0]     i_stat_value,
    input  logic                  i_stat_last,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic                  i_pready,
    input  logic [ADDR_W-1:0]     i_paddr,
    input  logic [PDATA_W-1:0]    i_pwdata,
    output int                    o_pending,
    output int                    o_mismatches
);

    localparam logic [DATA_W-1:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [DATA_W-1:0] S64_MIN = 64'h8000_0000_0000_0000;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [DATA_W-1:0] value;
        logic              last;
    } t_stat_word;

    t_stat_word expected_stats[$];
    int         mismatch_count;

    logic [MODE_W-1:0]      mode_reg;
    logic [INTERVAL_W-1:0]  interval_reg;
    logic                   force_reg;
    logic                   enabled_reg;

    logic signed [DATA_W-1:0] min_seen;
    logic signed [DATA_W-1:0] max_seen;
    logic [DATA_W-1:0]        value_sum;
    logic [COUNT_WIDTH-1:0]   sample_count;
    logic [TIME_WIDTH:0]      next_deadline;

    // Signed mean of the wrapping sum, rounded toward zero.
    function automatic logic [DATA_W-1:0] trunc_average(input logic [DATA_W-1:0] sum,
                                                        input logic [COUNT_WIDTH-1:0] count);
        logic [DATA_W-1:0] mag;
        logic [DATA_W-1:0] divisor;
        logic [DATA_W-1:0] quo;
        divisor = count;
        mag     = sum[DATA_W-1] ? -sum : sum;
        quo     = mag / divisor;
        return sum[DATA_W-1] ? -quo : quo;
    endfunction

    task automatic clear_aggregates();
        min_seen     = S64_MAX;
        max_seen     = S64_MIN;
        value_sum    = '0;
        sample_count = '0;
    endtask

    // Appends one predicted word at the tail of the queue.
    task automatic queue_word(input logic [KIND_W-1:0] kind,
                              input logic [DATA_W-1:0] value,
                              input logic last);
        t_stat_word word;
        word.kind  = kind;
        word.value = value;
        word.last  = last;
        expected_stats.insert(expected_stats.size(), word);
    endtask

    task automatic fold_sample(input logic [DATA_W-1:0] value,
                               input logic [TIME_WIDTH-1:0] stamp);
        logic                want_min;
        logic                want_max;
        logic                want_avg;
        logic [TIME_WIDTH:0] step_wide;
        logic [DATA_W-1:0]   mean;
        want_min  = (mode_reg == MODE_ALL) || (mode_reg == MODE_MIN_ONLY);
        want_max  = (mode_reg == MODE_ALL) || (mode_reg == MODE_MAX_ONLY);
        want_avg  = (mode_reg == MODE_ALL) || (mode_reg == MODE_AVG_ONLY);
        step_wide = interval_reg;

        if (sample_count != '1) begin
            sample_count = sample_count + 1'b1;
        end
        if (want_avg) begin
            value_sum = value_sum + value;
        end
        if (want_min && ($signed(value) < min_seen)) begin
            min_seen = value;
        end
        if (want_max && ($signed(value) > max_seen)) begin
            max_seen = value;
        end

        if (!enabled_reg) begin
            return;
        end
        if (!force_reg && ({1'b0, stamp} < next_deadline)) begin
            return;
        end
        next_deadline = {1'b0, stamp} + step_wide;

        if (sample_count != '0) begin
            mean = trunc_average(value_sum, sample_count);
            case (mode_reg)
                MODE_ALL: begin
                    queue_word(KIND_MIN, min_seen, 1'b0);
                    queue_word(KIND_MAX, max_seen, 1'b0);
                    queue_word(KIND_AVG, mean, 1'b1);
                end
                MODE_MIN_ONLY: queue_word(KIND_MIN, min_seen, 1'b1);
                MODE_MAX_ONLY: queue_word(KIND_MAX, max_seen, 1'b1);
                default:       queue_word(KIND_AVG, mean, 1'b1);
            endcase
        end
        clear_aggregates();
    endtask

    always @(posedge i_clk) begin
        t_stat_word want;
        if (!i_rst_n) begin
            mode_reg      = MODE_ALL;
            interval_reg  = '0;
            force_reg     = 1'b0;
            enabled_reg   = 1'b1;
            next_deadline = '0;
            clear_aggregates();
            expected_stats.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[3:2])
                    REG_MODE:     mode_reg     = i_pwdata[MODE_W-1:0];
                    REG_INTERVAL: interval_reg = i_pwdata[INTERVAL_W-1:0];
                    REG_FORCE:    force_reg    = i_pwdata[0];
                    REG_ENABLED:  enabled_reg  = i_pwdata[0];
                    default: ;
                endcase
            end

            if (i_stat_valid && i_stat_ready) begin
                if (expected_stats.size() == 0) begin
                    if (mismatch_count < 10) begin
                        $display("%0t: unexpected stat word kind %0d value %0d last %0d",
                                 $realtime, i_stat_kind, $signed(i_stat_value), i_stat_last);
                    end
                    mismatch_count++;
                end else begin
                    want = expected_stats.pop_front();
                    if (want.kind !== i_stat_kind || want.value !== i_stat_value ||
                        want.last !== i_stat_last) begin
                        if (mismatch_count < 10) begin
                            $display("%0t: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                                     $realtime, want.kind, $signed(want.value), want.last,
                                     i_stat_kind, $signed(i_stat_value), i_stat_last);
                        end
                        mismatch_count++;
                    end
                end
            end

            if (i_sample_valid && i_sample_ready) begin
                fold_sample(i_sample_value, i_sample_time);
            end
        end
        o_pending    = expected_stats.size();
        o_mismatches = mismatch_count;
    end

endmodule

### verif/tb.sv
// Top of the bench. This module only makes stimulus and gives the verdict;
// stats_monitor beside the block does all prediction and comparison.
module tb;
    import mmasr_pkg::*;

    localparam int TIME_W        = 48;
    localparam int COUNT_W       = 32;
    // Long enough for a report with the average to finish, so this covers any
    // sample still in flight that produces no word.
    localparam int SETTLE_CYCLES = 80;
    localparam int HOLD_CYCLES   = 600;
    localparam int PHASE_ITEMS   = 44;

    localparam logic [DATA_W-1:0] S64_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [DATA_W-1:0] S64_MIN  = 64'h8000_0000_0000_0000;
    localparam logic [DATA_W-1:0] MINUS1   = '1;
    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    mmasr_in_if #(.TIME_WIDTH(TIME_W)) sample_ch ();
    mmasr_out_if                       stat_ch ();

    int                pending_words;
    int                mismatches;
    int                src_idle_pct;
    int                sink_stall_pct;
    bit                hold_go;
    logic [31:0]       cur_interval;
    logic [TIME_W-1:0] stamp_now;

    min_max_avg_stats_reporter #(
        .TIME_WIDTH  (TIME_W),
        .COUNT_WIDTH (COUNT_W)
    ) i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (sample_ch),
        .o_stat   (stat_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    stats_monitor #(
        .TIME_WIDTH  (TIME_W),
        .COUNT_WIDTH (COUNT_W)
    ) i_monitor (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sample_valid (sample_ch.valid),
        .i_sample_ready (sample_ch.ready),
        .i_sample_value (sample_ch.sample_value),
        .i_sample_time  (sample_ch.sample_time),
        .i_stat_valid   (stat_ch.valid),
        .i_stat_ready   (stat_ch.ready),
        .i_stat_kind    (stat_ch.stat_kind),
        .i_stat_value   (stat_ch.stat_value),
        .i_stat_last    (stat_ch.last),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_pready       (pready),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .o_pending      (pending_words),
        .o_mismatches   (mismatches)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs or a word never arrives.
    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    // The stat sink. Ready changes on the falling edge. A hold request makes
    // it refuse words for a long stretch so that the output register and then
    // the sample input back up while the source keeps offering.
    initial begin
        stat_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_go) begin
                hold_go       = 1'b0;
                stat_ch.ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else if (i_rst_n) begin
                stat_ch.ready = ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    // One register write: a setup cycle, then an access cycle that completes
    // at the rising edge where pready is seen high. Entered and left on a
    // falling edge.
    task automatic write_reg(input logic [1:0] index, input logic [PDATA_W-1:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {index, 2'b00};
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Wait until every predicted word has come out, then let the block finish
    // any sample that reports nothing.
    task automatic drain();
        sample_ch.valid = 1'b0;
        while (pending_words != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Registers change only while the block is idle.
    task automatic program_settings(input logic [MODE_W-1:0] mode,
                                    input logic [31:0] interval,
                                    input logic force_rpt,
                                    input logic enable);
        drain();
        write_reg(REG_MODE, PDATA_W'(mode));
        write_reg(REG_INTERVAL, interval);
        write_reg(REG_FORCE, PDATA_W'(force_rpt));
        write_reg(REG_ENABLED, PDATA_W'(enable));
        cur_interval = interval;
    endtask

    // Offers one sample word and returns on the falling edge after it was
    // taken. Valid stays high so that back-to-back words need no toggle; the
    // idle gaps lower it.
    task automatic send_sample(input logic [DATA_W-1:0] value,
                               input logic [TIME_W-1:0] stamp);
        while ($urandom_range(99) < src_idle_pct) begin
            sample_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        sample_ch.valid        = 1'b1;
        sample_ch.sample_value = value;
        sample_ch.sample_time  = stamp;
        do @(posedge i_clk); while (!sample_ch.ready);
        @(negedge i_clk);
    endtask

    // Sample values: some extremes, many small values so that averages and
    // the min/max ordering stay readable, and full-width random words.
    function automatic logic [DATA_W-1:0] random_sample_value();
        int pick;
        int near_zero;
        pick = $urandom_range(99);
        if (pick < 15) begin
            case ($urandom_range(6))
                0:       return S64_MAX;
                1:       return S64_MIN;
                2:       return '0;
                3:       return MINUS1;
                4:       return 64'd1;
                5:       return S64_MIN + 64'd1;
                default: return S64_MAX - 64'd1;
            endcase
        end
        if (pick < 50) begin
            near_zero = $urandom_range(2000);
            near_zero = near_zero - 1000;
            return DATA_W'(near_zero);
        end
        return {$urandom, $urandom};
    endfunction

    // A run of random samples on a mostly rising time line. Steps are drawn
    // around the report interval so that roughly every other sample crosses
    // the deadline; a few samples go back in time or jump far ahead.
    task automatic run_random_phase(input int idle_kind, input bit with_holdoff);
        int                pick;
        logic [TIME_W-1:0] stamp;
        logic [31:0]       span;
        @(posedge i_clk);
        case (idle_kind)
            0: begin
                src_idle_pct   = 0;
                sink_stall_pct = 0;
            end
            1: begin
                src_idle_pct   = 55;
                sink_stall_pct = 0;
            end
            2: begin
                src_idle_pct   = 0;
                sink_stall_pct = 55;
            end
            default: begin
                src_idle_pct   = 35;
                sink_stall_pct = 35;
            end
        endcase
        hold_go = with_holdoff;
        @(negedge i_clk);

        span = (cur_interval > 32'h7FFF_FFFF) ? 32'hFFFF_FFFF : cur_interval * 2 + 32'd2;
        repeat (PHASE_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 4) begin
                // Late sample: at or before the current point of the time line.
                stamp = TIME_W'({16'($urandom), $urandom} % ({1'b0, stamp_now} + 49'd1));
            end else if (pick < 6) begin
                // Jump anywhere in the time range, and carry on from there.
                stamp     = {16'($urandom), $urandom};
                stamp_now = stamp;
            end else if (pick < 16) begin
                stamp = stamp_now;
            end else begin
                stamp     = stamp_now + TIME_W'($urandom_range(span));
                stamp_now = stamp;
            end
            send_sample(random_sample_value(), stamp);
        end
    endtask

    initial begin
        sample_ch.valid        = 1'b0;
        sample_ch.sample_value = '0;
        sample_ch.sample_time  = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        cur_interval   = '0;
        stamp_now      = '0;
        i_rst_n        = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed part, first under the reset settings: all three stats,
        // zero interval, no forcing, enabled. Both value extremes and both
        // time extremes each report at once.
        send_sample(S64_MAX, '0);
        send_sample(S64_MIN, '0);
        send_sample('0, TIME_MAX);
        // The deadline now sits at the top of the time range, so an early
        // sample is only folded in and the next one at the top reports both.
        send_sample(MINUS1, 48'd5);
        send_sample(64'd1, TIME_MAX);

        // With the widest interval the deadline passes the 48-bit time range
        // after the next report. Two largest values make the sum wrap.
        program_settings(MODE_ALL, 32'hFFFF_FFFF, 1'b0, 1'b1);
        send_sample(S64_MAX, 48'd1);
        send_sample(S64_MAX, 48'd2);
        send_sample(64'd3, 48'd3);
        send_sample(S64_MIN + 64'd1, TIME_MAX);
        // No time can reach the deadline now, not even the largest one.
        send_sample(-64'sd7, '0);
        send_sample('0, TIME_MAX);

        // Forcing reports regardless of the deadline; the mean of -7 over
        // three samples must round toward zero.
        program_settings(MODE_ALL, 32'd0, 1'b1, 1'b1);
        send_sample('0, 48'd4);

        // Mode change between reports: samples kept under min-only leave the
        // sum alone but still count, so the later average is diluted.
        program_settings(MODE_MIN_ONLY, 32'd0, 1'b0, 1'b1);
        send_sample(-64'sd5, 48'd1);
        send_sample(64'd50, 48'd2);
        program_settings(MODE_AVG_ONLY, 32'd0, 1'b1, 1'b1);
        send_sample(64'd30, 48'd3);

        // Disabled: even forced or late samples report nothing and leave the
        // deadline where it was.
        program_settings(MODE_MAX_ONLY, 32'd10, 1'b1, 1'b0);
        send_sample(S64_MIN, 48'd100);
        send_sample(-64'sd3, TIME_MAX);
        program_settings(MODE_MAX_ONLY, 32'd10, 1'b0, 1'b1);
        send_sample(64'd7, 48'd2);
        send_sample(64'd8, 48'd3);
        program_settings(MODE_MIN_ONLY, 32'd0, 1'b1, 1'b1);
        send_sample(S64_MAX, '0);

        // Random part: each phase takes new settings and an idling pattern.
        // The forced mode-all phase also carries the long sink hold-off, since every
        // sample there yields three words and backs the block up quickly.
        stamp_now = '0;
        program_settings(MODE_ALL, 32'd0, 1'b0, 1'b1);
        run_random_phase(0, 1'b0);
        program_settings(MODE_MIN_ONLY, 32'd100, 1'b0, 1'b1);
        run_random_phase(1, 1'b0);
        program_settings(MODE_MAX_ONLY, 32'hFFFF_FFFF, 1'b0, 1'b1);
        run_random_phase(2, 1'b0);
        program_settings(MODE_AVG_ONLY, 32'd7, 1'b0, 1'b1);
        run_random_phase(3, 1'b0);
        program_settings(MODE_ALL, 32'd1000, 1'b1, 1'b1);
        run_random_phase(0, 1'b1);
        // Disabled phase: aggregates build up over many samples and their average
        // comes out in the first report of the next phase.
        program_settings(MODE_ALL, 32'd50, 1'b0, 1'b0);
        run_random_phase(1, 1'b0);
        program_settings(MODE_AVG_ONLY, 32'd20, 1'b1, 1'b1);
        run_random_phase(2, 1'b0);
        program_settings(MODE_ALL, 32'd3, 1'b0, 1'b1);
        run_random_phase(3, 1'b0);
        program_settings(MODE_MIN_ONLY, 32'd0, 1'b1, 1'b1);
        run_random_phase(0, 1'b0);
        program_settings(MODE_ALL, $urandom_range(5000), 1'b0, 1'b1);
        run_random_phase(3, 1'b0);

        drain();
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
